// ===== rtl/gmim_pkg.sv =====
// Shared definitions for the gap-method merge block: sizes, branch conditions,
// sequencer step codes, control word layout and the microcode table.
// No dependencies; imported by the sequencer and the top level.
`default_nettype none

package gmim_pkg;

   localparam int DEPTH = 64;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int DW    = 64;

   // Branch condition selects.
   localparam logic [2:0] COND_NONE      = 3'd0;
   localparam logic [2:0] COND_LAST_ACC  = 3'd1;
   localparam logic [2:0] COND_DRAIN     = 3'd2;
   localparam logic [2:0] COND_PAIR_END  = 3'd3;
   localparam logic [2:0] COND_NO_SWAP   = 3'd4;
   localparam logic [2:0] COND_GAP_ONE   = 3'd5;
   localparam logic [2:0] COND_EMIT_DONE = 3'd6;

   // Step addresses of the program.
   localparam logic [2:0] STEP_LOAD  = 3'd0;
   localparam logic [2:0] STEP_GINIT = 3'd1;
   localparam logic [2:0] STEP_TEST  = 3'd2;
   localparam logic [2:0] STEP_CMP   = 3'd3;
   localparam logic [2:0] STEP_SWAP  = 3'd4;
   localparam logic [2:0] STEP_NGAP  = 3'd5;
   localparam logic [2:0] STEP_EINIT = 3'd6;
   localparam logic [2:0] STEP_EMIT  = 3'd7;

   typedef struct packed {
      logic       accept;
      logic       gap_init;
      logic       gap_next;
      logic       pair_clr;
      logic       pair_inc;
      logic       rd_pair;
      logic       wr_lo;
      logic       wr_hi;
      logic       emit;
      logic [2:0] cond;
      logic [2:0] tgt;
      logic [2:0] nxt;
   } ucode_type;

   // Decoded controls handed from the sequencer to the datapath.
   typedef struct packed {
      logic accept;
      logic gap_init;
      logic gap_next;
      logic pair_clr;
      logic pair_inc;
      logic rd_pair;
      logic wr_lo;
      logic wr_hi;
      logic emit;
   } ctl_type;

   // Datapath status that the branch conditions test.
   typedef struct packed {
      logic last_acc;
      logic drain;
      logic pair_end;
      logic no_swap;
      logic gap_one;
      logic emit_done;
   } flags_type;

   function automatic ucode_type ucode_rom(input logic [2:0] pc);
      ucode_type w;
      w = '0;
      unique case (pc)
         STEP_LOAD: begin
            w.accept = 1'b1;
            w.cond   = COND_LAST_ACC;
            w.tgt    = STEP_GINIT;
            w.nxt    = STEP_LOAD;
         end
         STEP_GINIT: begin
            w.gap_init = 1'b1;
            w.pair_clr = 1'b1;
            w.cond     = COND_DRAIN;
            w.tgt      = STEP_GINIT;
            w.nxt      = STEP_TEST;
         end
         STEP_TEST: begin
            w.rd_pair = 1'b1;
            w.cond    = COND_PAIR_END;
            w.tgt     = STEP_NGAP;
            w.nxt     = STEP_CMP;
         end
         STEP_CMP: begin
            w.wr_lo    = 1'b1;
            w.pair_inc = 1'b1;
            w.cond     = COND_NO_SWAP;
            w.tgt      = STEP_TEST;
            w.nxt      = STEP_SWAP;
         end
         STEP_SWAP: begin
            w.wr_hi = 1'b1;
            w.cond  = COND_NONE;
            w.tgt   = STEP_TEST;
            w.nxt   = STEP_TEST;
         end
         STEP_NGAP: begin
            w.gap_next = 1'b1;
            w.pair_clr = 1'b1;
            w.cond     = COND_GAP_ONE;
            w.tgt      = STEP_EINIT;
            w.nxt      = STEP_TEST;
         end
         STEP_EINIT: begin
            w.pair_clr = 1'b1;
            w.cond     = COND_NONE;
            w.tgt      = STEP_EMIT;
            w.nxt      = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_EMIT_DONE;
            w.tgt  = STEP_LOAD;
            w.nxt  = STEP_EMIT;
         end
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gmim_ram.sv =====
// Generic RAM: one write port and two read ports with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module gmim_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rda_en,
   input  wire [$clog2(DEPTH)-1:0]  rda_addr,
   output logic [WIDTH-1:0]         rda_data,
   input  wire                      rdb_en,
   input  wire [$clog2(DEPTH)-1:0]  rdb_addr,
   output logic [WIDTH-1:0]         rdb_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rda_en) begin
         rda_data <= mem_ff[rda_addr];
      end
      if (rdb_en) begin
         rdb_data <= mem_ff[rdb_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gmim_useq.sv =====
// Microcode sequencer: step counter, program table lookup and branch select.
// Depends on gmim_pkg for the control word layout and the program.
`default_nettype none

module gmim_useq
   import gmim_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  flags_type  flags,
   output ctl_type    ctl
);

   logic [2:0] pc_ff, pc_in;
   ucode_type  word;
   logic       taken;

   assign word = ucode_rom(pc_ff);

   always_comb begin
      case (word.cond)
         COND_LAST_ACC:  taken = flags.last_acc;
         COND_DRAIN:     taken = flags.drain;
         COND_PAIR_END:  taken = flags.pair_end;
         COND_NO_SWAP:   taken = flags.no_swap;
         COND_GAP_ONE:   taken = flags.gap_one;
         COND_EMIT_DONE: taken = flags.emit_done;
         default:        taken = 1'b0;
      endcase
   end

   // Most operations belong to the fall-through path and are dropped when the
   // branch is taken; the pair step and the second swap write are never dropped,
   // and request accept and emit are qualified by their own handshakes in the datapath.
   always_comb begin
      ctl.accept   = word.accept;
      ctl.gap_init = word.gap_init & ~taken;
      ctl.gap_next = word.gap_next & ~taken;
      ctl.pair_clr = word.pair_clr & ~taken;
      ctl.pair_inc = word.pair_inc;
      ctl.rd_pair  = word.rd_pair & ~taken;
      ctl.wr_lo    = word.wr_lo & ~taken;
      ctl.wr_hi    = word.wr_hi;
      ctl.emit     = word.emit;
      pc_in        = taken ? word.tgt : word.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gap_method_inplace_merge.sv =====
// Top level of the gap-method merge of two sorted arrays.
// Depends on gmim_pkg, gmim_ram and gmim_useq.
`default_nettype none

// Channel   Direction  tdata               tuser         tlast
// req_      in         value [63:0]        from_second   last_in
// rsp_      out        merged_value[63:0]  to_second     last_out
//
// Loading takes one request per cycle. After the request marked last, the
// block waits for its previous output to be taken, then sets up the first
// gap and runs the gap passes: each compare reads a pair and then, on a swap,
// writes the lower slot and then the upper slot, since the single RAM write
// port needs two writes; each pass ends with the closing test and the gap
// update. Emitting takes a setup step and then one result per cycle while the
// receiver takes them, read straight from the RAM's registered port. A stalled
// response holds its data; new requests are taken while the last result of the
// previous set still waits. Reset is synchronous and clears the counters and
// the sequencer; the store itself is not cleared.

module gap_method_inplace_merge
   import gmim_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [63:0] value
   input  wire         req_tuser,   // [0] from_second
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] merged_value
   output logic        rsp_tuser,   // [0] to_second
   output logic        rsp_tlast
);

   ctl_type   ctl;
   flags_type flags;

   logic [CW-1:0] total_count_ff, total_count_in;
   logic [CW-1:0] first_count_ff, first_count_in;
   logic [CW-1:0] gap_size_ff, gap_size_in;
   logic [CW-1:0] pair_index_ff, pair_index_in;
   logic [AW-1:0] hi_addr_ff;
   logic          dv_ff, dv_in;
   logic          to_second_ff, last_out_ff;

   logic          req_fire, load_wr, emit_fire, emit_last;
   logic [CW:0]   hi_sum;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic          wr_en;
   logic signed [DW-1:0] rda_data, rdb_data;

   gmim_useq u_useq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   assign req_tready = ctl.accept;
   assign req_fire   = req_tvalid & req_tready;
   assign load_wr    = req_fire & (total_count_ff < CW'(DEPTH));

   // An emit read is issued whenever the output register is free or drains now.
   assign emit_fire = ctl.emit & (~dv_ff | rsp_tready);
   assign emit_last = (pair_index_ff + CW'(1)) == total_count_ff;
   assign hi_sum    = {1'b0, pair_index_ff} + {1'b0, gap_size_ff};

   always_comb begin
      flags.last_acc  = req_fire & req_tlast;
      flags.drain     = dv_ff;
      flags.pair_end  = hi_sum >= {1'b0, total_count_ff};
      flags.no_swap   = ~(rda_data > rdb_data);
      flags.gap_one   = gap_size_ff == CW'(1);
      flags.emit_done = emit_fire & emit_last;
   end

   // The swap writes the lower slot first with the upper value, then the upper
   // slot with the lower value that still sits in port A's output register.
   always_comb begin
      wr_en   = load_wr | ctl.wr_lo | ctl.wr_hi;
      wr_addr = hi_addr_ff;
      wr_data = rda_data;
      if (load_wr) begin
         wr_addr = total_count_ff[AW-1:0];
         wr_data = req_tdata;
      end else if (ctl.wr_lo) begin
         wr_addr = pair_index_ff[AW-1:0];
         wr_data = rdb_data;
      end
   end

   gmim_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rda_en   (ctl.rd_pair | emit_fire),
      .rda_addr (pair_index_ff[AW-1:0]),
      .rda_data (rda_data),
      .rdb_en   (ctl.rd_pair),
      .rdb_addr (hi_sum[AW-1:0]),
      .rdb_data (rdb_data)
   );

   always_comb begin
      total_count_in = total_count_ff;
      first_count_in = first_count_ff;
      gap_size_in    = gap_size_ff;
      pair_index_in  = pair_index_ff;

      // The first array's length grows only until a second-array element shows up.
      if (load_wr) begin
         total_count_in = total_count_ff + CW'(1);
         if (!req_tuser && first_count_ff == total_count_ff) begin
            first_count_in = first_count_ff + CW'(1);
         end
      end
      if (ctl.gap_init) begin
         gap_size_in = (total_count_ff >> 1) + {{(CW-1){1'b0}}, total_count_ff[0]};
      end else if (ctl.gap_next) begin
         gap_size_in = (gap_size_ff >> 1) + {{(CW-1){1'b0}}, gap_size_ff[0]};
      end
      if (ctl.pair_clr) begin
         pair_index_in = '0;
      end else if (ctl.pair_inc | emit_fire) begin
         pair_index_in = pair_index_ff + CW'(1);
      end
      if (emit_fire && emit_last) begin
         total_count_in = '0;
         first_count_in = '0;
         gap_size_in    = '0;
         pair_index_in  = '0;
      end
   end

   always_comb begin
      if (emit_fire) begin
         dv_in = 1'b1;
      end else if (rsp_tready) begin
         dv_in = 1'b0;
      end else begin
         dv_in = dv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_count_ff <= '0;
         first_count_ff <= '0;
         gap_size_ff    <= '0;
         pair_index_ff  <= '0;
         dv_ff          <= 1'b0;
      end else begin
         total_count_ff <= total_count_in;
         first_count_ff <= first_count_in;
         gap_size_ff    <= gap_size_in;
         pair_index_ff  <= pair_index_in;
         dv_ff          <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_pair) begin
         hi_addr_ff <= hi_sum[AW-1:0];
      end
      if (emit_fire) begin
         to_second_ff <= pair_index_ff >= first_count_ff;
         last_out_ff  <= emit_last;
      end
   end

   assign rsp_tvalid = dv_ff;
   assign rsp_tdata  = rda_data;
   assign rsp_tuser  = to_second_ff;
   assign rsp_tlast  = last_out_ff;

`ifndef NO_ASSERTIONS
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({load_wr, ctl.wr_lo, ctl.wr_hi}))
      else $error("store written from two sources at once");

   a_first_le_total: assert property (@(posedge clock) disable iff (reset)
      first_count_ff <= total_count_ff)
      else $error("first array longer than the stored set");

   a_pair_in_range: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_pair |-> (hi_sum < {1'b0, total_count_ff}))
      else $error("compare reads past the stored set");

   a_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && emit_last) |=> (total_count_ff == '0 && first_count_ff == '0))
      else $error("counters not cleared after the final result");

   a_no_read_over_output: assert property (@(posedge clock) disable iff (reset)
      (dv_ff && !rsp_tready) |-> !ctl.rd_pair)
      else $error("sort read would clobber a held result");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gap_method_inplace_merge: a merge predictor, random
// stream stalls on both channels, and a result checker. Depends on gmim_pkg and the RTL.

module tb_top;
   import gmim_pkg::*;

   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off for the pressure test
   localparam int STALL_LIMIT  = 4000;  // cycles with no transfer before the run is failed
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 20;
   localparam int SET_MAX      = 80;

   typedef struct packed {
      logic signed [63:0] value;
      logic               second;
      logic               last;
   } merged_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [63:0] value
   logic        req_tuser = 1'b0; // [0] from_second
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // [63:0] merged_value
   logic        rsp_tuser;        // [0] to_second
   logic        rsp_tlast;

   gap_method_inplace_merge u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The predictor keeps its own copy of the element store and the two counts.
   // Expected results wait in merged_expect_q in the order the block must emit them.
   logic signed [63:0] held_elems [0:DEPTH-1];
   int unsigned        held_len  = 0;
   int unsigned        first_len = 0;
   merged_elem_type    merged_expect_q [$];

   // Run bookkeeping.
   int errors          = 0;
   int items_sent      = 0;
   int items_dropped   = 0;
   int sets_merged     = 0;
   int results_checked = 0;
   int longest_set     = 0;

   // Idling controls, changed by the tests.
   bit sender_idles = 1'b0;
   bit rsp_stalls   = 1'b0;
   bit hold_pending = 1'b0;
   int hold_left    = 0;
   int stall_left   = 0;

   // Staging buffer for one data set before it is streamed in.
   logic signed [63:0] set_vals   [0:SET_MAX-1];
   logic               set_second [0:SET_MAX-1];

   // Folds one accepted request into the predictor. A request marked last runs the
   // gap passes over the held elements and queues one expected result per element.
   task automatic absorb_element(input logic signed [63:0] value, input logic second,
                                 input logic last);
      int unsigned        gap;
      int unsigned        i;
      logic signed [63:0] swap_tmp;
      merged_elem_type    elem;
      if (held_len < DEPTH) begin
         // The first array only grows while no second-array element has been seen.
         if (!second && first_len == held_len) first_len++;
         held_elems[held_len] = value;
         held_len++;
      end else begin
         items_dropped++;
      end
      if (last) begin
         gap = (held_len >> 1) + (held_len & 1);
         while (gap > 0) begin
            for (i = 0; i + gap < held_len; i++) begin
               if (held_elems[i] > held_elems[i + gap]) begin
                  swap_tmp             = held_elems[i];
                  held_elems[i]        = held_elems[i + gap];
                  held_elems[i + gap]  = swap_tmp;
               end
            end
            gap = (gap == 1) ? 0 : (gap >> 1) + (gap & 1);
         end
         for (i = 0; i < held_len; i++) begin
            elem.value  = held_elems[i];
            elem.second = (i >= first_len);
            elem.last   = (i + 1 == held_len);
            merged_expect_q.push_back(elem);
         end
         if (held_len > longest_set) longest_set = held_len;
         held_len  = 0;
         first_len = 0;
         sets_merged++;
      end
   endtask

   // Sender gaps: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (!sender_idles) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // Element values lean on the extremes and on small numbers so that equal
   // keys and sign boundaries show up often; the rest is full-width random.
   function automatic logic signed [63:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return 64'sh8000_0000_0000_0000;
         1:       return 64'sh7FFF_FFFF_FFFF_FFFF;
         2:       return 64'sd0;
         3:       return -64'sd1;
         4, 5:    return $signed(64'($urandom_range(0, 200))) - 64'sd100;
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   // Insertion sort of set_vals[lo .. hi-1].
   function automatic void sort_range(int lo, int hi);
      int                 j;
      int                 k;
      logic signed [63:0] key;
      for (j = lo + 1; j < hi; j++) begin
         key = set_vals[j];
         k   = j - 1;
         while (k >= lo && set_vals[k] > key) begin
            set_vals[k + 1] = set_vals[k];
            k--;
         end
         set_vals[k + 1] = key;
      end
   endfunction

   // Builds a well-formed data set: two independently sorted arrays back to back.
   function automatic void fill_sorted_set(int len, int n_first);
      int k;
      for (k = 0; k < len; k++) begin
         set_vals[k]   = rand_value();
         set_second[k] = (k >= n_first);
      end
      sort_range(0, n_first);
      sort_range(n_first, len);
   endfunction

   // Offers one request, starting at a falling edge, and returns at the falling
   // edge after it was taken. Valid stays high so the next request can follow at once.
   task automatic send_item(input logic [63:0] value, input logic second, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= second;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_element(value, second, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_set(input int len);
      int k;
      for (k = 0; k < len; k++) send_item(set_vals[k], set_second[k], k == len - 1);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   // Hand-picked sets: lone elements, the signed extremes, one array empty, and a
   // first-array element that arrives after the second array has started.
   task automatic test_directed();
      sender_idles = 1'b0;
      rsp_stalls   = 1'b0;
      send_item(64'd5, 1'b0, 1'b1);
      send_item(64'h8000_0000_0000_0000, 1'b1, 1'b1);
      // Both arrays reach from the most negative to the most positive value.
      send_item(64'h8000_0000_0000_0000, 1'b0, 1'b0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
      send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
      send_item(64'h8000_0000_0000_0000, 1'b1, 1'b0);
      send_item(64'd0, 1'b1, 1'b0);
      send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
      // No first array at all.
      send_item(-64'sd3, 1'b1, 1'b0);
      send_item(64'd7, 1'b1, 1'b1);
      // No second array at all.
      send_item(-64'sd1, 1'b0, 1'b0);
      send_item(64'd0, 1'b0, 1'b0);
      send_item(64'd1, 1'b0, 1'b1);
      // Late first-array tags belong to the second part.
      send_item(64'd10, 1'b0, 1'b0);
      send_item(64'd2, 1'b1, 1'b0);
      send_item(64'd1, 1'b0, 1'b0);
      send_item(-64'sd4, 1'b0, 1'b1);
      stop_sending();
   endtask

   // One set that overflows the store: the first DEPTH requests fill it exactly,
   // the rest are dropped, and the last flag arrives on a dropped request.
   task automatic test_store_full();
      sender_idles = 1'b1;
      rsp_stalls   = 1'b1;
      fill_sorted_set(DEPTH + 2, 20);
      send_set(DEPTH + 2);
      stop_sending();
   endtask

   // Mostly well-formed sets with random content and sizes; about one in five
   // sets is noise with unsorted values and random array tags.
   task automatic test_random_sets();
      int start_count;
      int len;
      int k;
      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         sender_idles = ($urandom_range(0, 3) != 0);
         rsp_stalls   = ($urandom_range(0, 3) != 0);
         len = ($urandom_range(0, 14) == 0) ? $urandom_range(30, DEPTH) : $urandom_range(1, 12);
         if (len > RANDOM_ITEMS - (items_sent - start_count)) begin
            len = RANDOM_ITEMS - (items_sent - start_count);
         end
         if ($urandom_range(0, 4) == 0) begin
            for (k = 0; k < len; k++) begin
               set_vals[k]   = {$urandom(), $urandom()};
               set_second[k] = $urandom_range(0, 1);
            end
         end else begin
            fill_sorted_set(len, $urandom_range(0, len));
         end
         send_set(len);
      end
      stop_sending();
   endtask

   // The receiver holds off for a long stretch while two sets are offered back to
   // back, so the block stalls its output and then its input.
   task automatic test_backpressure();
      sender_idles = 1'b0;
      rsp_stalls   = 1'b0;
      hold_pending = 1'b1;
      fill_sorted_set(12, 5);
      send_set(12);
      fill_sorted_set(12, 7);
      send_set(12);
      stop_sending();
   endtask

   // Receiver: ready changes on the falling edge. A pending hold-off wins, then any
   // stall in progress, then a fresh random stall when stalls are enabled.
   always @(negedge clock) begin
      if (hold_pending) begin
         hold_left    = HOLD_CYCLES;
         hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Each result taken is compared with the oldest expectation, field by field.
   always @(posedge clock) begin : result_check
      merged_elem_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (merged_expect_q.size() == 0) begin
            $error("result with nothing expected: merged_value %0d", $signed(rsp_tdata));
            errors++;
         end else begin
            want = merged_expect_q.pop_front();
            results_checked++;
            if (rsp_tdata !== want.value) begin
               $error("merged_value: expected %0d, got %0d", want.value, $signed(rsp_tdata));
               errors++;
            end
            if (rsp_tuser !== want.second) begin
               $error("to_second: expected %0d, got %0d", want.second, rsp_tuser);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_out: expected %0d, got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog: too many cycles in a row without a transfer on either channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_store_full();
      test_random_sets();
      test_backpressure();
      // Let every expected result come out, then watch a little longer for strays.
      while (merged_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: merged %0d data sets from %0d requests, longest set %0d elements",
               sets_merged, items_sent, longest_set);
      $display("tb: %0d results checked, %0d requests dropped at a full store, %0d mismatches",
               results_checked, items_dropped, errors);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
